FILE: rtl/core/mtt_pkg.sv
// Shared constants, codes and cell types for the multi-timer table.
package mtt_pkg;

    localparam int TIMER_SLOTS   = 16;
    localparam int SLOT_W        = $clog2(TIMER_SLOTS);
    localparam int INTERVAL_BITS = 16;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_ADD     = 2'd1,
        FUNC_DELETE  = 2'd2,
        FUNC_RESTART = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_EXPIRED  = 3'd0,
        KIND_ADDED    = 3'd1,
        KIND_FULL     = 3'd2,
        KIND_DONE     = 3'd3,
        KIND_BAD_SLOT = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        CELL_HOLD    = 2'd0,
        CELL_ADVANCE = 2'd1,
        CELL_INSERT  = 2'd2,
        CELL_REMOVE  = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic                     valid;
        logic [SLOT_W-1:0]        slot;
        logic [INTERVAL_BITS-1:0] interval;
        logic [INTERVAL_BITS-1:0] elapsed;
        logic                     rep;
        logic                     expired;
    } t_entry;

    typedef struct packed {
        t_cell_op          op;
        logic              by_slot;
        logic [SLOT_W-1:0] key;
        t_entry            ent;
    } t_cell_cmd;

endpackage

FILE: rtl/core/multi_timer_table.sv
// Multi-timer table: a sorted chain of timer cells with a sequencing controller.
// Timers sit in a row of cells in firing order (by interval, ties in insertion
// order); the row shifts as one to insert or remove a timer. One item is worked
// at a time. An add is one insertion pass, a delete one removal pass and a restart
// a removal then an insertion pass, each followed by a reply; a bad slot or a full
// table gets the reply alone. A tick advances every timer, then each expired timer
// is reported and taken out in a removal pass, and a repeat timer then needs an
// insertion pass; a stalled output beat holds back the reply and each report.
module multi_timer_table (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_func,
    input  logic [mtt_pkg::INTERVAL_BITS-1:0]  i_interval,
    input  logic                               i_repeat_req,
    input  logic [mtt_pkg::SLOT_W-1:0]         i_timer_id,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [2:0]                         o_kind,
    output logic [mtt_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_last
);
    import mtt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ADVANCE, ST_SCAN, ST_REMOVE, ST_INSERT, ST_REPLY
    } t_state;

    t_state             r_state;
    t_state             r_ins_next;
    logic [TIMER_SLOTS-1:0] r_used;
    logic               r_restart;
    logic [SLOT_W-1:0]  r_key;
    t_entry             r_pend;
    t_kind              r_reply_kind;
    logic [SLOT_W-1:0]  r_reply_slot;
    logic               r_emitted;
    logic               r_out_valid;
    logic               n_out_valid;
    t_kind              r_kind;
    logic [SLOT_W-1:0]  r_slot;
    logic               r_last;

    t_cell_cmd          cmd;
    t_entry             ents [TIMER_SLOTS];
    logic [TIMER_SLOTS:0] ins_chain;
    logic [TIMER_SLOTS:0] pre_chain;
    logic [TIMER_SLOTS-1:0] sel_vec;
    logic [TIMER_SLOTS-1:0] exp_vec;
    logic [TIMER_SLOTS-1:0] cell_valid;
    t_entry             sel_ent;
    t_entry             pend_ent;
    logic               any_exp;
    logic               more_exp;
    logic               out_free;
    logic [SLOT_W-1:0]  free_slot;

    assign ins_chain[0] = 1'b0;
    assign pre_chain[0] = 1'b0;

    for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
        t_entry left_ent;
        t_entry right_ent;
        if (g == 0) begin : g_first
            assign left_ent = '0;
        end else begin : g_mid
            assign left_ent = ents[g-1];
        end
        if (g == TIMER_SLOTS - 1) begin : g_tail
            assign right_ent = '0;
        end else begin : g_body
            assign right_ent = ents[g+1];
        end
        mtt_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cmd      (cmd),
            .i_left     (left_ent),
            .i_right    (right_ent),
            .i_ins_left (ins_chain[g]),
            .i_pre_left (pre_chain[g]),
            .o_entry    (ents[g]),
            .o_ins      (ins_chain[g+1]),
            .o_pre      (pre_chain[g+1]),
            .o_sel      (sel_vec[g])
        );
        assign exp_vec[g]    = ents[g].valid && ents[g].expired;
        assign cell_valid[g] = ents[g].valid;
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign any_exp  = |exp_vec;
    assign more_exp = |(exp_vec & ~sel_vec);

    always_comb begin
        sel_ent   = '0;
        free_slot = '0;
        for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (sel_vec[i]) begin
                sel_ent = sel_ent | ents[i];
            end
        end
        for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot = SLOT_W'(i);
            end
        end
        // A timer taken out of the row goes back in with a cleared count.
        pend_ent         = sel_ent;
        pend_ent.elapsed = '0;
        pend_ent.expired = 1'b0;
    end

    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        if (out_free && (((r_state == ST_SCAN) && any_exp) || (r_state == ST_REPLY))) begin
            n_out_valid = 1'b1;
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.op      = CELL_HOLD;
        cmd.by_slot = (r_state == ST_REMOVE);
        cmd.key     = r_key;
        cmd.ent     = r_pend;
        case (r_state)
            ST_ADVANCE: cmd.op = CELL_ADVANCE;
            ST_SCAN:    cmd.op = (any_exp && out_free) ? CELL_REMOVE : CELL_HOLD;
            ST_REMOVE:  cmd.op = CELL_REMOVE;
            ST_INSERT:  cmd.op = CELL_INSERT;
            default:    cmd.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_key        <= i_timer_id;
                        r_restart    <= (i_func == FUNC_RESTART);
                        r_emitted    <= 1'b0;
                        r_reply_slot <= '0;
                        case (t_func'(i_func))
                            FUNC_TICK: r_state <= ST_ADVANCE;
                            FUNC_ADD: begin
                                if (&r_used) begin
                                    r_reply_kind <= KIND_FULL;
                                    r_state      <= ST_REPLY;
                                end else begin
                                    r_pend.valid      <= 1'b1;
                                    r_pend.slot       <= free_slot;
                                    r_pend.interval   <= i_interval;
                                    r_pend.elapsed    <= '0;
                                    r_pend.rep        <= i_repeat_req;
                                    r_pend.expired    <= 1'b0;
                                    r_used[free_slot] <= 1'b1;
                                    r_reply_kind      <= KIND_ADDED;
                                    r_reply_slot      <= free_slot;
                                    r_ins_next        <= ST_REPLY;
                                    r_state           <= ST_INSERT;
                                end
                            end
                            default: begin
                                if (!r_used[i_timer_id]) begin
                                    r_reply_kind <= KIND_BAD_SLOT;
                                    r_state      <= ST_REPLY;
                                end else begin
                                    r_reply_kind <= KIND_DONE;
                                    r_state      <= ST_REMOVE;
                                end
                            end
                        endcase
                    end
                end
                ST_ADVANCE: r_state <= ST_SCAN;
                ST_SCAN: begin
                    if (!any_exp) begin
                        if (r_emitted) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_reply_kind <= KIND_DONE;
                            r_state      <= ST_REPLY;
                        end
                    end else if (out_free) begin
                        // Report the first expired timer and pull it out of the row.
                        r_kind    <= KIND_EXPIRED;
                        r_slot    <= sel_ent.slot;
                        r_last    <= !more_exp;
                        r_emitted <= 1'b1;
                        r_pend    <= pend_ent;
                        if (sel_ent.rep) begin
                            r_ins_next <= ST_SCAN;
                            r_state    <= ST_INSERT;
                        end else begin
                            r_used[sel_ent.slot] <= 1'b0;
                        end
                    end
                end
                ST_REMOVE: begin
                    r_pend <= pend_ent;
                    if (r_restart) begin
                        r_ins_next <= ST_REPLY;
                        r_state    <= ST_INSERT;
                    end else begin
                        r_used[r_key] <= 1'b0;
                        r_state       <= ST_REPLY;
                    end
                end
                ST_INSERT: r_state <= r_ins_next;
                ST_REPLY: begin
                    if (out_free) begin
                        r_kind  <= r_reply_kind;
                        r_slot  <= r_reply_slot;
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_slot      = r_slot;
    assign o_last      = r_last;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(sel_vec))
        else $error("more than one cell selected for removal");

    a_idle_no_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (exp_vec == '0))
        else $error("expired timer left over after a tick");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(cell_valid) == $countones(r_used)))
        else $error("listed timers disagree with allocated slots");

endmodule

FILE: rtl/core/mtt_cell.sv
// One list position of the timer table: holds a timer and trades it with its neighbors.
module mtt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtt_pkg::t_cell_cmd i_cmd,
    input  mtt_pkg::t_entry   i_left,
    input  mtt_pkg::t_entry   i_right,
    input  logic              i_ins_left,
    input  logic              i_pre_left,
    output mtt_pkg::t_entry   o_entry,
    output logic              o_ins,
    output logic              o_pre,
    output logic              o_sel
);
    import mtt_pkg::*;

    t_entry                   r_ent;
    t_entry                   n_ent;
    logic                     match;
    logic [INTERVAL_BITS-1:0] bumped;

    always_comb begin
        match  = r_ent.valid && (i_cmd.by_slot ? (r_ent.slot == i_cmd.key) : r_ent.expired);
        o_sel  = match && !i_pre_left;
        o_pre  = i_pre_left || match;
        // The new timer goes in front of the first timer with a larger interval.
        o_ins  = !r_ent.valid || (r_ent.interval > i_cmd.ent.interval);
        bumped = (r_ent.elapsed != '1) ? r_ent.elapsed + 1'b1 : r_ent.elapsed;
        n_ent  = r_ent;
        case (i_cmd.op)
            CELL_ADVANCE: begin
                if (r_ent.valid) begin
                    if (bumped >= r_ent.interval) begin
                        n_ent.elapsed = '0;
                        n_ent.expired = 1'b1;
                    end else begin
                        n_ent.elapsed = bumped;
                    end
                end
            end
            CELL_INSERT: begin
                if (i_ins_left) begin
                    n_ent = i_left;
                end else if (o_ins) begin
                    n_ent = i_cmd.ent;
                end
            end
            CELL_REMOVE: begin
                if (o_pre) begin
                    n_ent = i_right;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid   <= 1'b0;
            r_ent.expired <= 1'b0;
        end else begin
            r_ent <= n_ent;
        end
    end

    assign o_entry = r_ent;

endmodule
